[hw/rtl/lis_pkg.sv]
// Shared constants and types for the longest increasing subsequence block.
package lis_pkg;

    localparam int MAX_ITEMS = 1024;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int VAL_W     = 32;
    localparam int LEN_W     = 11;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic        [CNT_W-1:0] chain;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINAL
    } t_state;

endpackage

[hw/rtl/longest_increasing_subsequence.sv]
// Longest strictly increasing subsequence engine over a single-port entry memory.
// Each accepted word is latched, then the scan reads every stored entry once (skipped
//   when empty or full); the final state stores the entry unless full and registers the result.
// Throughput is bounded by the single memory read port that walks every earlier entry once;
//   a new word is taken only when the block is idle again after publishing the last result.
// Reset (synchronous, active low) clears the count, best length and control state;
//   the entry memory is not cleared. The receiver cannot stall results.
module longest_increasing_subsequence (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [lis_pkg::VAL_W-1:0]   i_value,
    input  logic                               i_last,
    output logic                               o_valid,
    output logic        [lis_pkg::LEN_W-1:0]   o_length,
    output logic                               o_final_res,
    output logic                               o_overflow
);
    import lis_pkg::*;

    // Entry memory: value and chain length of every stored element.
    t_entry mem [MAX_ITEMS];

    // Control state.
    t_state             r_state,  n_state;
    logic [CNT_W-1:0]   r_count,  n_count;    // stored elements of the sequence
    logic [CNT_W-1:0]   r_best,   n_best;     // running maximum chain length
    logic [ADDR_W-1:0]  r_addr,   n_addr;     // scan read pointer
    logic               r_rd_vld, n_rd_vld;   // read data of last cycle is live
    logic               r_valid,  n_valid;    // result strobe

    // Payload of the word at work.
    logic signed [VAL_W-1:0] r_value, n_value;
    logic                    r_last,  n_last;
    logic                    r_ovf,   n_ovf;
    logic [CNT_W-1:0]        r_chain, n_chain;

    // Result registers.
    logic [LEN_W-1:0]        r_length, n_length;
    logic                    r_final,  n_final;
    logic                    r_res_ovf, n_res_ovf;

    // Memory port.
    t_entry             r_rd_data;
    logic               rd_en;
    logic               wr_en;
    t_entry             wr_data;

    logic [CNT_W-1:0]   cand;
    logic [CNT_W-1:0]   chain_upd;
    logic               take;

    // Candidate from the entry read last cycle: extend its chain by one
    // when its value is strictly below the incoming word and the result beats the current chain.
    assign cand      = r_rd_data.chain + CNT_W'(1);
    assign take      = r_rd_vld && (r_rd_data.value < r_value) && (cand > r_chain);
    assign chain_upd = take ? cand : r_chain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_best   <= '0;
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_best   <= n_best;
            r_addr   <= n_addr;
            r_rd_vld <= n_rd_vld;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value   <= n_value;
        r_last    <= n_last;
        r_ovf     <= n_ovf;
        r_chain   <= n_chain;
        r_length  <= n_length;
        r_final   <= n_final;
        r_res_ovf <= n_res_ovf;
    end

    // Synchronous memory: one read or one write per cycle, read data registered.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[r_addr];
        end
        if (wr_en) begin
            mem[r_count[ADDR_W-1:0]] <= wr_data;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_best    = r_best;
        n_addr    = r_addr;
        n_rd_vld  = 1'b0;
        n_valid   = 1'b0;
        n_value   = r_value;
        n_last    = r_last;
        n_ovf     = r_ovf;
        n_chain   = r_chain;
        n_length  = r_length;
        n_final   = r_final;
        n_res_ovf = r_res_ovf;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        wr_data.value = r_value;
        wr_data.chain = chain_upd;
        busy      = (r_state != ST_IDLE);

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    // Latch the word; skip the scan when full or empty.
                    n_value = i_value;
                    n_last  = i_last;
                    n_ovf   = (r_count == CNT_W'(MAX_ITEMS));
                    n_chain = CNT_W'(1);
                    n_addr  = '0;
                    if ((r_count == CNT_W'(MAX_ITEMS)) || (r_count == '0)) begin
                        n_state = ST_FINAL;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // Issue one read per cycle, fold in the entry read last cycle.
                rd_en    = 1'b1;
                n_rd_vld = 1'b1;
                n_chain  = chain_upd;
                n_addr   = r_addr + ADDR_W'(1);
                if ({1'b0, r_addr} == r_count - CNT_W'(1)) begin
                    n_state = ST_FINAL;
                end
            end
            ST_FINAL: begin
                // Fold the last read, store the entry unless full, publish the result; clear after the last word.
                n_state = ST_IDLE;
                n_valid = 1'b1;
                n_final   = r_last;
                n_res_ovf = r_ovf;
                if (r_ovf) begin
                    n_length = LEN_W'(r_best);
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    if (chain_upd > r_best) begin
                        n_best   = chain_upd;
                        n_length = LEN_W'(chain_upd);
                    end else begin
                        n_length = LEN_W'(r_best);
                    end
                end
                if (r_last) begin
                    n_count = '0;
                    n_best  = '0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_valid     = r_valid;
    assign o_length    = r_length;
    assign o_final_res = r_final;
    assign o_overflow  = r_res_ovf;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ITEMS))
        else $error("element count beyond capacity");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held more than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_final_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_final_res) |-> (r_count == '0 && r_best == '0))
        else $error("sequence not cleared after final word");

    a_length_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_overflow) |-> (o_length != '0))
        else $error("stored word returned zero length");

endmodule
